### rtl/sal_pkg.sv
// types and constants for the sorted linked list block
// holds the request/response beat structs, pool sizes, command and status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

   // pool geometry
   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int KEY_W  = 32;

   // link value that marks the end of a chain
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

   // command codes
   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_DELETE = 3'd1;
   localparam logic [2:0] CMD_SEARCH = 3'd2;
   localparam logic [2:0] CMD_COUNT  = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]              command;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  entries;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/sorted_array_linked_list.sv
// Sorted linked list over a fixed pool of 64 slots with a free list. A command beat is taken
// when start is high and busy is low; its one result beat appears on rsp_data for exactly one
// cycle, marked by rsp_valid, and cannot be held off. Count, clear, unknown commands and an
// insert into a full pool answer in the cycle after the command. Search and delete walk the
// list from the head over up to 64 slots; insert first reads the free-list successor, then
// walks. A state that rewrites the predecessor's link is added before the answer when that
// link has to change. The walk takes one hop per cycle, as the key and link memories have a
// registered read. Clear takes effect at once; there is no clearing pass after reset.
// depends on sal_pkg
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_linked_list (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire sal_pkg::req_type req_data,
   output logic                 rsp_valid,
   output sal_pkg::rsp_type     rsp_data
);

   import sal_pkg::*;

   // controller states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_END   = 3'd3;
   localparam logic [2:0] S_LINK  = 3'd4;

   // map any out-of-pool link onto the end marker
   function automatic logic [LINK_W-1:0] norm_link(input logic [LINK_W-1:0] v);
      norm_link = (v >= LINK_W'(SLOTS)) ? LINK_NONE : v;
   endfunction

   // memories, read data registered
   logic signed [KEY_W-1:0] key_mem [SLOTS];
   logic [LINK_W-1:0]       link_mem [SLOTS];
   logic signed [KEY_W-1:0] key_rd_ff;
   logic [LINK_W-1:0]       link_rd_ff;
   logic [SLOT_W-1:0]       rd_addr_ff;
   logic                    link_vld_rd_ff;
   logic [SLOTS-1:0]        link_vld_ff;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [LINK_W-1:0] list_head_ff, list_head_in;
   logic [LINK_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // per-command working registers
   req_type           req_ff, req_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] pos_next_ff, pos_next_in;
   logic [LINK_W-1:0] free_next_ff, free_next_in;
   logic [LINK_W-1:0] lw_data_ff, lw_data_in;
   logic              found_ff, found_in;
   rsp_type           rsp_ff, rsp_in;

   // memory access controls
   logic [SLOT_W-1:0] rd_addr;
   logic              lw_en;
   logic [SLOT_W-1:0] lw_addr;
   logic [LINK_W-1:0] lw_data;
   logic              kw_en;
   logic              clr_vld;
   logic [LINK_W-1:0] link_eff;
   logic [LINK_W-1:0] head_norm;

   // a link never written since reset or clear reads as the next slot
   assign link_eff  = norm_link(link_vld_rd_ff ? link_rd_ff
                                               : LINK_W'(rd_addr_ff) + LINK_W'(1));
   assign head_norm = norm_link(list_head_ff);

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      pos_next_in  = pos_next_ff;
      free_next_in = free_next_ff;
      lw_data_in   = lw_data_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rd_addr      = free_head_ff[SLOT_W-1:0];
      lw_en        = 1'b0;
      lw_addr      = prev_ff[SLOT_W-1:0];
      lw_data      = lw_data_ff;
      kw_en        = 1'b0;
      clr_vld      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.command)
                  CMD_INSERT: begin
                     if (norm_link(free_head_ff) == LINK_NONE) begin
                        rsp_in       = '{status: ST_FULL, slot: '0, entries: count_ff};
                        rsp_valid_in = 1'b1;
                     end else begin
                        // fetch the free-list successor first
                        rd_addr  = free_head_ff[SLOT_W-1:0];
                        state_in = S_FETCH;
                     end
                  end
                  CMD_DELETE, CMD_SEARCH: begin
                     cur_in   = head_norm;
                     prev_in  = LINK_NONE;
                     found_in = 1'b0;
                     rd_addr  = head_norm[SLOT_W-1:0];
                     state_in = (head_norm == LINK_NONE) ? S_END : S_WALK;
                  end
                  CMD_CLEAR: begin
                     list_head_in = LINK_NONE;
                     free_head_in = '0;
                     count_in     = '0;
                     clr_vld      = 1'b1;
                     rsp_in       = '{status: ST_OK, slot: '0, entries: '0};
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_in       = '{status: ST_OK, slot: '0, entries: count_ff};
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_FETCH: begin
            free_next_in = link_eff;
            cur_in       = head_norm;
            prev_in      = LINK_NONE;
            found_in     = 1'b0;
            rd_addr      = head_norm[SLOT_W-1:0];
            state_in     = (head_norm == LINK_NONE) ? S_END : S_WALK;
         end

         // one hop per cycle: the slot at cur_ff has just been read
         S_WALK: begin
            if (key_rd_ff < req_ff.key) begin
               prev_in = cur_ff;
               cur_in  = link_eff;
               rd_addr = link_eff[SLOT_W-1:0];
               if (link_eff == LINK_NONE) begin
                  found_in = 1'b0;
                  state_in = S_END;
               end
            end else begin
               found_in    = (key_rd_ff == req_ff.key);
               pos_next_in = link_eff;
               state_in    = S_END;
            end
         end

         S_END: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            case (req_ff.command)
               CMD_INSERT: begin
                  if (found_ff) begin
                     rsp_in = '{status: ST_DUPLICATE, slot: '0, entries: count_ff};
                  end else begin
                     // new slot links to the first key not below it
                     kw_en        = 1'b1;
                     lw_en        = 1'b1;
                     lw_addr      = free_head_ff[SLOT_W-1:0];
                     lw_data      = cur_ff;
                     free_head_in = free_next_ff;
                     count_in     = count_ff + CNT_W'(1);
                     rsp_in       = '{status: ST_OK, slot: free_head_ff[SLOT_W-1:0],
                                      entries: count_ff + CNT_W'(1)};
                     if (prev_ff == LINK_NONE) begin
                        list_head_in = free_head_ff;
                     end else begin
                        lw_data_in   = free_head_ff;
                        rsp_valid_in = 1'b0;
                        state_in     = S_LINK;
                     end
                  end
               end
               CMD_DELETE: begin
                  if (!found_ff) begin
                     rsp_in = '{status: ST_NOT_FOUND, slot: '0, entries: count_ff};
                  end else begin
                     // push the removed slot onto the free list
                     lw_en        = 1'b1;
                     lw_addr      = cur_ff[SLOT_W-1:0];
                     lw_data      = norm_link(free_head_ff);
                     free_head_in = cur_ff;
                     count_in     = (count_ff != '0) ? count_ff - CNT_W'(1) : count_ff;
                     rsp_in       = '{status: ST_OK, slot: cur_ff[SLOT_W-1:0],
                                      entries: count_in};
                     if (prev_ff == LINK_NONE) begin
                        list_head_in = pos_next_ff;
                     end else begin
                        lw_data_in   = pos_next_ff;
                        rsp_valid_in = 1'b0;
                        state_in     = S_LINK;
                     end
                  end
               end
               CMD_SEARCH: begin
                  if (found_ff) begin
                     rsp_in = '{status: ST_OK, slot: cur_ff[SLOT_W-1:0], entries: count_ff};
                  end else begin
                     rsp_in = '{status: ST_NOT_FOUND, slot: '0, entries: count_ff};
                  end
               end
               default: begin
                  rsp_in = '{status: ST_OK, slot: '0, entries: count_ff};
               end
            endcase
         end

         // rewrite the predecessor's link, then answer
         S_LINK: begin
            lw_en        = 1'b1;
            lw_addr      = prev_ff[SLOT_W-1:0];
            lw_data      = lw_data_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         list_head_ff <= LINK_NONE;
         free_head_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      pos_next_ff  <= pos_next_in;
      free_next_ff <= free_next_in;
      lw_data_ff   <= lw_data_in;
      found_ff     <= found_in;
      rsp_ff       <= rsp_in;
   end

   // link valid bits: cleared by reset and clear, set on each link write
   always_ff @(posedge clock) begin
      if (reset || clr_vld) begin
         link_vld_ff <= '0;
      end else if (lw_en) begin
         link_vld_ff[lw_addr] <= 1'b1;
      end
   end

   // key memory
   always_ff @(posedge clock) begin
      if (kw_en) begin
         key_mem[free_head_ff[SLOT_W-1:0]] <= req_ff.key;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   // link memory
   always_ff @(posedge clock) begin
      if (lw_en) begin
         link_mem[lw_addr] <= lw_data;
      end
      link_rd_ff     <= link_mem[rd_addr];
      link_vld_rd_ff <= link_vld_ff[rd_addr];
      rd_addr_ff     <= rd_addr;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("key count above pool size");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while a command is still in progress");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither in progress nor answered");

   a_slot_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.slot == '0))
      else $error("nonzero slot on an error result");

endmodule

`default_nettype wire
